>>> rtl/tapp_pkg.sv
// Package for the three-axis position PID: payload structs, configuration
// struct, register indexes, controller states, datapath commands and helpers.
// No dependencies.
package tapp_pkg;

   // Input item: current and target position and velocity, signed Q16.16
   typedef struct packed {
      logic signed [31:0] current_pos_x;
      logic signed [31:0] current_pos_y;
      logic signed [31:0] current_pos_z;
      logic signed [31:0] current_vel_x;
      logic signed [31:0] current_vel_y;
      logic signed [31:0] current_vel_z;
      logic signed [31:0] target_pos_x;
      logic signed [31:0] target_pos_y;
      logic signed [31:0] target_pos_z;
      logic signed [31:0] target_vel_x;
      logic signed [31:0] target_vel_y;
      logic signed [31:0] target_vel_z;
   } req_type;

   // Result item: commanded acceleration, signed Q16.16
   typedef struct packed {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
   } rsp_type;

   // Configuration register contents
   typedef struct packed {
      logic [63:0] p_gains;
      logic [63:0] i_gains;
      logic [63:0] d_gains;
      logic [30:0] max_horizontal_accel;
      logic [30:0] max_vertical_accel;
      logic [30:0] max_horizontal_integral;
      logic [30:0] max_vertical_integral;
      logic [15:0] loop_period;
   } cfg_type;

   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_P_GAINS    = 4'd0,
      CSR_I_GAINS    = 4'd1,
      CSR_D_GAINS    = 4'd2,
      CSR_MAX_H_ACC  = 4'd3,
      CSR_MAX_V_ACC  = 4'd4,
      CSR_MAX_H_INT  = 4'd5,
      CSR_MAX_V_INT  = 4'd6,
      CSR_LOOP_PER   = 4'd7
   } csr_index_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INC_MUL,
      ST_INC_ADD,
      ST_NORM_LOAD,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_M,
      ST_CMP,
      ST_SQRT,
      ST_CEIL,
      ST_DIV_MUL,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_NORM_STORE,
      ST_CLAMP,
      ST_GP,
      ST_GI,
      ST_GD,
      ST_GS,
      ST_OUT
   } state_type;

   // Datapath operations
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_INC_MUL,
      OP_INC_ADD,
      OP_NORM_LOAD,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_M,
      OP_CMP,
      OP_SQRT_STEP,
      OP_CEIL,
      OP_DIV_MUL,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_NORM_STORE,
      OP_CLAMP,
      OP_GP,
      OP_GI,
      OP_GD,
      OP_GS,
      OP_OUT
   } op_type;

   // Command from controller to datapath
   typedef struct packed {
      op_type     op;
      logic [1:0] axis;   // axis, or component (bit 0) during division
      logic       pass;   // 0: integral limit pass, 1: output limit pass
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic fits;        // squared norm within squared limit
      logic out_busy;    // result register full and not taken this cycle
   } status_type;

   // Saturate a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      logic signed [51:0] hi;
      logic signed [51:0] lo;
      hi = 52'sh7FFFFFFF;
      lo = -52'sh80000000;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   // Clamp a signed value symmetrically to +/- m
   function automatic logic signed [31:0] sym_clamp(input logic signed [31:0] v,
                                                   input logic [30:0] m);
      logic signed [32:0] v33;
      logic signed [32:0] m33;
      v33 = {v[31], v};
      m33 = {2'b00, m};
      if (v33 > m33) begin
         return {1'b0, m};
      end else if (v33 < -m33) begin
         return 32'(-m33);
      end else begin
         return v;
      end
   endfunction

endpackage

>>> rtl/tapp_ctrl.sv
// Controller state machine for the three-axis position PID.
// Depends on tapp_pkg; drives tapp_dp through cmd_type and reads status_type.
module tapp_ctrl import tapp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       pass_ff, pass_in;
   logic [4:0] cnt_ff, cnt_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 2'd0;
         pass_ff  <= 1'b0;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      pass_in  = pass_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_INC_MUL;
               axis_in  = 2'd0;
               pass_in  = 1'b0;
            end
         end
         ST_INC_MUL: state_in = ST_INC_ADD;
         ST_INC_ADD: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_NORM_LOAD;
               axis_in  = 2'd0;
            end else begin
               state_in = ST_INC_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_NORM_LOAD: state_in = ST_SQ_X;
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SQ_M;
         ST_SQ_M:      state_in = ST_CMP;
         ST_CMP: begin
            cnt_in = 5'd0;
            if (status.fits) begin
               state_in = ST_NORM_STORE;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_CEIL;
            end
         end
         ST_CEIL: begin
            state_in = ST_DIV_MUL;
            axis_in  = 2'd0;
         end
         ST_DIV_MUL:  state_in = ST_DIV_INIT;
         ST_DIV_INIT: begin
            state_in = ST_DIV_STEP;
            cnt_in   = 5'd0;
         end
         ST_DIV_STEP: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            if (axis_ff == 2'd0) begin
               state_in = ST_DIV_MUL;
               axis_in  = 2'd1;
            end else begin
               state_in = ST_NORM_STORE;
            end
         end
         ST_NORM_STORE: state_in = ST_CLAMP;
         ST_CLAMP: begin
            axis_in = 2'd0;
            if (pass_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_GP;
            end
         end
         ST_GP: state_in = ST_GI;
         ST_GI: state_in = ST_GD;
         ST_GD: state_in = ST_GS;
         ST_GS: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_NORM_LOAD;
               axis_in  = 2'd0;
               pass_in  = 1'b1;
            end else begin
               state_in = ST_GP;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.axis  = axis_ff;
      cmd.pass  = pass_ff;
      cmd.op    = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_INC_MUL:    cmd.op = OP_INC_MUL;
         ST_INC_ADD:    cmd.op = OP_INC_ADD;
         ST_NORM_LOAD:  cmd.op = OP_NORM_LOAD;
         ST_SQ_X:       cmd.op = OP_SQ_X;
         ST_SQ_Y:       cmd.op = OP_SQ_Y;
         ST_SQ_M:       cmd.op = OP_SQ_M;
         ST_CMP:        cmd.op = OP_CMP;
         ST_SQRT:       cmd.op = OP_SQRT_STEP;
         ST_CEIL:       cmd.op = OP_CEIL;
         ST_DIV_MUL:    cmd.op = OP_DIV_MUL;
         ST_DIV_INIT:   cmd.op = OP_DIV_INIT;
         ST_DIV_STEP:   cmd.op = OP_DIV_STEP;
         ST_DIV_DONE:   cmd.op = OP_DIV_DONE;
         ST_NORM_STORE: cmd.op = OP_NORM_STORE;
         ST_CLAMP:      cmd.op = OP_CLAMP;
         ST_GP:         cmd.op = OP_GP;
         ST_GI:         cmd.op = OP_GI;
         ST_GD:         cmd.op = OP_GD;
         ST_GS:         cmd.op = OP_GS;
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.op = OP_OUT;
            end
         end
         default:       cmd.op = OP_NOP;
      endcase
   end

endmodule

>>> rtl/tapp_dp.sv
// Datapath for the three-axis position PID: shared 33x33 multiplier,
// bit-serial square root and divider, integral state and result register.
// Depends on tapp_pkg; commanded by tapp_ctrl.
module tapp_dp import tapp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  cfg_type    cfg,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic signed [31:0] ep_ff [3];
   logic signed [31:0] ed_ff [3];
   logic signed [31:0] integ_ff [3];
   logic signed [31:0] acc_ff [3];
   logic signed [31:0] nx_ff, ny_ff;
   logic        [30:0] m_ff;
   logic signed [65:0] mul_ff;
   logic        [63:0] s_ff;
   logic        [31:0] root_ff;
   logic        [33:0] srem_ff;
   logic        [31:0] n_ff;
   logic        [31:0] drem_ff;
   logic        [31:0] dlo_ff;
   logic               neg_ff;
   logic signed [51:0] t_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic        [31:0] kp, ki, kd;
   logic signed [51:0] mul_shr;
   logic signed [32:0] diff [6];

   // Gains for the current axis: horizontal on x and y, vertical on z
   assign kp = (cmd.axis == 2'd2) ? cfg.p_gains[31:0] : cfg.p_gains[63:32];
   assign ki = (cmd.axis == 2'd2) ? cfg.i_gains[31:0] : cfg.i_gains[63:32];
   assign kd = (cmd.axis == 2'd2) ? cfg.d_gains[31:0] : cfg.d_gains[63:32];

   // Previous product shifted right by 16, rounding toward minus infinity
   assign mul_shr = {{2{mul_ff[65]}}, mul_ff[65:16]};

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_INC_MUL: begin
            mul_a = {ep_ff[cmd.axis][31], ep_ff[cmd.axis]};
            mul_b = {17'd0, cfg.loop_period};
         end
         OP_SQ_X: begin
            mul_a = {nx_ff[31], nx_ff};
            mul_b = {nx_ff[31], nx_ff};
         end
         OP_SQ_Y: begin
            mul_a = {ny_ff[31], ny_ff};
            mul_b = {ny_ff[31], ny_ff};
         end
         OP_SQ_M: begin
            mul_a = {2'b00, m_ff};
            mul_b = {2'b00, m_ff};
         end
         OP_DIV_MUL: begin
            mul_a = cmd.axis[0] ? {ny_ff[31], ny_ff} : {nx_ff[31], nx_ff};
            mul_b = {2'b00, m_ff};
         end
         OP_GP: begin
            mul_a = {1'b0, kp};
            mul_b = {ep_ff[cmd.axis][31], ep_ff[cmd.axis]};
         end
         OP_GI: begin
            mul_a = {1'b0, ki};
            mul_b = {integ_ff[cmd.axis][31], integ_ff[cmd.axis]};
         end
         OP_GD: begin
            mul_a = {1'b0, kd};
            mul_b = {ed_ff[cmd.axis][31], ed_ff[cmd.axis]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Position and velocity differences, exact before saturation
   assign diff[0] = {req_data.target_pos_x[31], req_data.target_pos_x}
                  - {req_data.current_pos_x[31], req_data.current_pos_x};
   assign diff[1] = {req_data.target_pos_y[31], req_data.target_pos_y}
                  - {req_data.current_pos_y[31], req_data.current_pos_y};
   assign diff[2] = {req_data.target_pos_z[31], req_data.target_pos_z}
                  - {req_data.current_pos_z[31], req_data.current_pos_z};
   assign diff[3] = {req_data.target_vel_x[31], req_data.target_vel_x}
                  - {req_data.current_vel_x[31], req_data.current_vel_x};
   assign diff[4] = {req_data.target_vel_y[31], req_data.target_vel_y}
                  - {req_data.current_vel_y[31], req_data.current_vel_y};
   assign diff[5] = {req_data.target_vel_z[31], req_data.target_vel_z}
                  - {req_data.current_vel_z[31], req_data.current_vel_z};

   // Status towards the controller
   assign status.fits     = (s_ff <= mul_ff[63:0]);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // Integral state, the only reset payload
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         integ_ff[2] <= '0;
      end else begin
         priority case (cmd.op)
            OP_INC_ADD: begin
               integ_ff[cmd.axis] <= sat32({{20{integ_ff[cmd.axis][31]}},
                                            integ_ff[cmd.axis]} + mul_shr);
            end
            OP_NORM_STORE: begin
               if (!cmd.pass) begin
                  integ_ff[0] <= nx_ff;
                  integ_ff[1] <= ny_ff;
               end
            end
            OP_CLAMP: begin
               if (!cmd.pass) begin
                  integ_ff[2] <= sym_clamp(integ_ff[2], cfg.max_vertical_integral);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      logic [35:0] st;
      logic [35:0] trial;
      logic [32:0] dt;
      logic [65:0] mag;
      st    = {srem_ff, s_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      dt    = {drem_ff, dlo_ff[31]};
      mag   = mul_ff[65] ? 66'(-mul_ff) : mul_ff;

      mul_ff <= prod;
      unique case (cmd.op)
         OP_LOAD: begin
            for (int a = 0; a < 3; a++) begin
               ep_ff[a] <= sat32({{19{diff[a][32]}}, diff[a]});
               ed_ff[a] <= sat32({{19{diff[a+3][32]}}, diff[a+3]});
            end
         end
         OP_NORM_LOAD: begin
            nx_ff <= cmd.pass ? acc_ff[0] : integ_ff[0];
            ny_ff <= cmd.pass ? acc_ff[1] : integ_ff[1];
            m_ff  <= cmd.pass ? cfg.max_horizontal_accel : cfg.max_horizontal_integral;
         end
         OP_SQ_Y: s_ff <= mul_ff[63:0];
         OP_SQ_M: s_ff <= s_ff + mul_ff[63:0];
         OP_CMP: begin
            root_ff <= '0;
            srem_ff <= '0;
         end
         OP_SQRT_STEP: begin
            // take two radicand bits, try the next root bit
            s_ff <= {s_ff[61:0], 2'b00};
            if (st >= trial) begin
               srem_ff <= 34'(st - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= st[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_CEIL: n_ff <= root_ff + {31'd0, (srem_ff != '0)};
         OP_DIV_INIT: begin
            neg_ff  <= mul_ff[65];
            drem_ff <= mag[63:32];
            dlo_ff  <= mag[31:0];
         end
         OP_DIV_STEP: begin
            // one quotient bit per cycle, shifted in below the dividend
            if (dt >= {1'b0, n_ff}) begin
               drem_ff <= 32'(dt - {1'b0, n_ff});
               dlo_ff  <= {dlo_ff[30:0], 1'b1};
            end else begin
               drem_ff <= dt[31:0];
               dlo_ff  <= {dlo_ff[30:0], 1'b0};
            end
         end
         OP_DIV_DONE: begin
            if (cmd.axis[0]) begin
               ny_ff <= neg_ff ? -dlo_ff : dlo_ff;
            end else begin
               nx_ff <= neg_ff ? -dlo_ff : dlo_ff;
            end
         end
         OP_NORM_STORE: begin
            if (cmd.pass) begin
               acc_ff[0] <= nx_ff;
               acc_ff[1] <= ny_ff;
            end
         end
         OP_CLAMP: begin
            if (cmd.pass) begin
               acc_ff[2] <= sym_clamp(acc_ff[2], cfg.max_vertical_accel);
            end
         end
         OP_GI: t_ff <= mul_shr;
         OP_GD: t_ff <= t_ff + mul_shr;
         OP_GS: acc_ff[cmd.axis] <= sat32(t_ff + mul_shr);
         default: begin
         end
      endcase
   end

   // Result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_ff.accel_x <= acc_ff[0];
         rsp_ff.accel_y <= acc_ff[1];
         rsp_ff.accel_z <= acc_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/three_axis_position_pid.sv
// Channel  | Ports                           | Transfer when
// ---------+---------------------------------+-------------------------------
// request  | req_valid, req_ready, req_data  | req_valid & req_ready
// response | rsp_valid, rsp_ready, rsp_data  | rsp_valid & rsp_ready
// config   | csr_we, csr_index, csr_wdata    | csr_we (no wait, no read-back)
//
// One item at a time. Each norm limit that triggers adds the bit-serial square
// root and two bit-serial divides behind the shared 33x33 multiplier, plus
// their set-up steps. Synchronous reset clears the integral, the configuration
// registers, the result valid flag and the state machine.
// A new request is taken once the result sits in the output register; a stalled
// response only holds the block when the next result is ready to go.
// Top level of the three-axis position PID; depends on tapp_pkg, tapp_ctrl
// and tapp_dp.
module three_axis_position_pid import tapp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // Configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_P_GAINS:   cfg_ff.p_gains <= csr_wdata;
            CSR_I_GAINS:   cfg_ff.i_gains <= csr_wdata;
            CSR_D_GAINS:   cfg_ff.d_gains <= csr_wdata;
            CSR_MAX_H_ACC: cfg_ff.max_horizontal_accel <= csr_wdata[30:0];
            CSR_MAX_V_ACC: cfg_ff.max_vertical_accel <= csr_wdata[30:0];
            CSR_MAX_H_INT: cfg_ff.max_horizontal_integral <= csr_wdata[30:0];
            CSR_MAX_V_INT: cfg_ff.max_vertical_integral <= csr_wdata[30:0];
            CSR_LOOP_PER:  cfg_ff.loop_period <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   tapp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tapp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/tapp_checker.sv
// Port-level checks for the three-axis position PID, bound to the top level.
// Depends on tapp_pkg and three_axis_position_pid.
module tapp_checker import tapp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // One item at a time: no request right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A result appears only at the end of work, while requests were held off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind three_axis_position_pid tapp_checker u_tapp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_top.sv
// Self-checking testbench for three_axis_position_pid: directed table, then random phases.
// Each result is checked against an internal PID predictor or a typed table row. Depends on tapp_pkg
// and the three_axis_position_pid RTL.
module tb_top;
   import tapp_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   three_axis_position_pid i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies and integral state of the predictor
   logic [63:0] kp_regs, ki_regs, kd_regs;
   logic [30:0] lim_h_acc, lim_v_acc, lim_h_int, lim_v_int;
   logic [15:0] period;
   longint      integ [3];

   rsp_type accel_due [$];
   int      mismatches = 0;
   int      send_idle = 0;
   int      recv_stall = 0;
   bit      hold_ask = 0;
   bit      hold_done = 0;
   bit      row_typed = 0;
   rsp_type row_want;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("** three_axis_position_pid: FAILED **");
      $finish;
   end

   function automatic longint sat_word(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
   endfunction

   // Integer square root, rounded up
   function automatic longint unsigned root_up(longint unsigned s);
      longint unsigned rem, res, b;
      rem = s;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      if (res * res < s) res++;
      return res;
   endfunction

   // Scale (x, y) down onto the circle of radius m when outside it
   task automatic limit_norm(inout longint x, inout longint y, input longint m);
      longint unsigned ax, ay, s, n;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      s = ax * ax + ay * ay;
      if (s > longint'(m) * longint'(m)) begin
         n = root_up(s);
         x = (x * m) / longint'(n);
         y = (y * m) / longint'(n);
      end
   endtask

   function automatic longint clamp_sym(longint v, longint m);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   // Advance the integral and form the commanded acceleration
   task automatic pid_step(input req_type r, output rsp_type o);
      longint cp [3], cv [3], tp [3], tv [3], ep [3], ed [3], acc [3];
      longint gp, gi, gd;
      cp = '{r.current_pos_x, r.current_pos_y, r.current_pos_z};
      cv = '{r.current_vel_x, r.current_vel_y, r.current_vel_z};
      tp = '{r.target_pos_x, r.target_pos_y, r.target_pos_z};
      tv = '{r.target_vel_x, r.target_vel_y, r.target_vel_z};
      for (int a = 0; a < 3; a++) begin
         ep[a] = sat_word(tp[a] - cp[a]);
         ed[a] = sat_word(tv[a] - cv[a]);
         integ[a] = sat_word(integ[a] + ((ep[a] * longint'(period)) >>> 16));
      end
      limit_norm(integ[0], integ[1], longint'(lim_h_int));
      integ[2] = clamp_sym(integ[2], longint'(lim_v_int));
      for (int a = 0; a < 3; a++) begin
         gp = (a < 2) ? longint'(kp_regs[63:32]) : longint'(kp_regs[31:0]);
         gi = (a < 2) ? longint'(ki_regs[63:32]) : longint'(ki_regs[31:0]);
         gd = (a < 2) ? longint'(kd_regs[63:32]) : longint'(kd_regs[31:0]);
         acc[a] = sat_word(((gp * ep[a]) >>> 16) + ((gi * integ[a]) >>> 16)
                           + ((gd * ed[a]) >>> 16));
      end
      limit_norm(acc[0], acc[1], longint'(lim_h_acc));
      acc[2] = clamp_sym(acc[2], longint'(lim_v_acc));
      o.accel_x = acc[0][31:0];
      o.accel_y = acc[1][31:0];
      o.accel_z = acc[2][31:0];
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Predict on every request transfer
   always @(posedge clock) begin
      rsp_type nxt;
      if (!reset && req_valid && req_ready) begin
         pid_step(req_data, nxt);
         accel_due.push_back(row_typed ? row_want : nxt);
      end
   end

   // Check every response transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (accel_due.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.accel_x, 32'h0);
         end else begin
            want = accel_due.pop_front();
            if (rsp_data.accel_x !== want.accel_x)
               report_mismatch("accel_x", rsp_data.accel_x, want.accel_x);
            if (rsp_data.accel_y !== want.accel_y)
               report_mismatch("accel_y", rsp_data.accel_y, want.accel_y);
            if (rsp_data.accel_z !== want.accel_z)
               report_mismatch("accel_z", rsp_data.accel_z, want.accel_z);
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_done = 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // Offer one request and hold it until transfer
   task automatic offer(input req_type d);
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Wait for outstanding results, then let the block settle
   task automatic settle();
      while (accel_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Write every register, in index order
   task automatic load_regs(input logic [63:0] v [8]);
      csr_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         @(negedge clock);
         req_valid <= 1'b0;
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v[idx];
         case (idx)
            CSR_P_GAINS:   kp_regs   = v[idx];
            CSR_I_GAINS:   ki_regs   = v[idx];
            CSR_D_GAINS:   kd_regs   = v[idx];
            CSR_MAX_H_ACC: lim_h_acc = v[idx][30:0];
            CSR_MAX_V_ACC: lim_v_acc = v[idx][30:0];
            CSR_MAX_H_INT: lim_h_int = v[idx][30:0];
            CSR_MAX_V_INT: lim_v_int = v[idx][30:0];
            CSR_LOOP_PER:  period    = v[idx][15:0];
            default: ;
         endcase
         idx = idx.next();
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Register settings: 0 all zero, 1 unity P gain with open limits, 2 tight limits, 3 all ones, 4 random
   task automatic apply_setting(input int sel);
      logic [63:0] v [8];
      case (sel)
         0: v = '{default: 64'h0};
         1: v = '{64'h00010000_00010000, 64'h00008000_00008000, 64'h00004000_00004000,
                  64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'hFFFF};
         2: v = '{64'h00030000_00020000, 64'h00010000_00018000, 64'h00008000_00004000,
                  64'h00010000, 64'h00008000, 64'h00004000, 64'h00002000, 64'h0666};
         3: v = '{default: 64'hFFFFFFFF_FFFFFFFF};
         default: begin
            for (int i = 0; i < 3; i++)
               v[i] = {$urandom_range(32'h3FFFF), $urandom_range(32'h3FFFF)};
            for (int i = 3; i < 7; i++)
               v[i] = ($urandom_range(1)) ? 64'($urandom & 32'h7FFFFFFF)
                                          : 64'($urandom_range(32'h7FFFF));
            v[7] = 64'($urandom_range(16'hFFFF));
         end
      endcase
      load_regs(v);
   endtask

   // Mix of full-range words and small values near zero
   function automatic req_type random_item();
      req_type r;
      logic [31:0] w;
      for (int f = 0; f < 12; f++) begin
         case ($urandom_range(9))
            0, 1:    w = $urandom;
            2:       w = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: w = $urandom_range(32'h1FFFFF) - 32'h100000;
         endcase
         r[383 - 32*f -: 32] = w;
      end
      return r;
   endfunction

   typedef struct {
      int      setting;
      bit      typed;
      req_type d;
      rsp_type want;
   } dir_row_t;

   localparam logic [31:0] PMAX = 32'h7FFFFFFF;
   localparam logic [31:0] NMAX = 32'h80000000;

   dir_row_t dir_rows [] = '{
      // all gains zero after reset: any input gives zero
      '{0, 1, '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX},
        '{0, 0, 0}},
      '{0, 1, '{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX},
        '{0, 0, 0}},
      '{0, 1, '{default: 32'h0}, '{0, 0, 0}},
      // error saturation in both directions, velocity extremes
      '{1, 0, '{NMAX, NMAX, NMAX, 0, 0, 0, PMAX, PMAX, PMAX, 0, 0, 0}, '{0, 0, 0}},
      '{1, 0, '{PMAX, PMAX, PMAX, 0, 0, 0, NMAX, NMAX, NMAX, 0, 0, 0}, '{0, 0, 0}},
      '{1, 0, '{0, 0, 0, NMAX, PMAX, NMAX, 0, 0, 0, PMAX, NMAX, PMAX}, '{0, 0, 0}},
      '{1, 0, '{32'h10000, 32'hFFFF0000, 32'h8000, 32'h100, 32'hFFFFFF00, 32'h1,
                32'h30000, 32'h20000, 32'hFFFF8000, 32'h0, 32'h0, 32'h0}, '{0, 0, 0}},
      '{1, 0, '{default: 32'h0}, '{0, 0, 0}},
      // tight limits: norm limit and clamp both engage
      '{2, 0, '{0, 0, 0, 0, 0, 0, 32'h50000, 32'h50000, 32'h50000, 0, 0, 0}, '{0, 0, 0}},
      '{2, 0, '{0, 0, 0, 0, 0, 0, 32'hFFFB0000, 32'h30000, 32'hFFFB0000, 0, 0, 0},
        '{0, 0, 0}},
      '{2, 0, '{0, 0, 0, 0, 0, 0, 32'h1, 32'hFFFFFFFF, 32'h1, 0, 0, 0}, '{0, 0, 0}},
      '{2, 0, '{NMAX, 0, NMAX, NMAX, 0, 0, PMAX, 0, PMAX, PMAX, 0, 0}, '{0, 0, 0}},
      // every gain and limit at its top
      '{3, 0, '{NMAX, PMAX, NMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, PMAX, NMAX, PMAX},
        '{0, 0, 0}},
      '{3, 0, '{0, 0, 0, 0, 0, 0, 32'h1, 32'h1, 32'hFFFFFFFF, 0, 0, 0}, '{0, 0, 0}}
   };

   initial begin
      int cur_setting;
      int stall_set [4] = '{0, 0, 70, 18};
      int idle_set [4]  = '{0, 70, 0, 18};
      int order [7]     = '{1, 2, 3, 4, 0, 2, 4};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      kp_regs = '0; ki_regs = '0; kd_regs = '0;
      lim_h_acc = '0; lim_v_acc = '0; lim_h_int = '0; lim_v_int = '0;
      period = '0;
      integ = '{0, 0, 0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; reload registers whenever the setting changes
      cur_setting = 0;
      foreach (dir_rows[k]) begin
         if (dir_rows[k].setting != cur_setting) begin
            @(negedge clock);
            req_valid <= 1'b0;
            settle();
            apply_setting(dir_rows[k].setting);
            cur_setting = dir_rows[k].setting;
         end
         row_typed = dir_rows[k].typed;
         row_want  = dir_rows[k].want;
         offer(dir_rows[k].d);
      end
      row_typed = 0;

      // random phases across settings and idling patterns
      for (int ph = 0; ph < 7; ph++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         settle();
         apply_setting(order[ph]);
         send_idle  = idle_set[ph % 4];
         recv_stall = stall_set[ph % 4];
         if (ph == 1) hold_ask = 1;
         for (int n = 0; n < 190; n++) begin
            if (ph == 3 && n == 100) begin
               // pause the sender until the block has drained
               @(negedge clock);
               req_valid <= 1'b0;
               while (accel_due.size() != 0) @(posedge clock);
            end
            offer(random_item());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      recv_stall = 0;
      settle();
      if (mismatches == 0) begin
         $display("** three_axis_position_pid: PASSED **");
      end else begin
         $display("** three_axis_position_pid: FAILED **");
      end
      $finish;
   end

endmodule
